// File: hdl/pwl_pkg.sv
// Package for the piecewise linear table interpolator.
// Shared widths, codes, controller states and the command/status structs.
// No dependencies.
package pwl_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int CFG_W          = 7;
	localparam int IDX_W          = 6;
	localparam int DATA_W         = 32;
	localparam int DIV_STEPS      = 64;
	localparam int DIV_CW         = 6;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_WALK,
		ST_EVAL,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	// read address select
	typedef enum logic [1:0] {
		RSEL_FIRST,
		RSEL_LAST,
		RSEL_ONE,
		RSEL_NEXT
	} rsel_t;

	// result source select
	typedef enum logic [2:0] {
		RES_EMPTY,
		RES_RD_Y,
		RES_PREV_Y,
		RES_CUR_Y,
		RES_INTERP
	} res_sel_t;

	typedef struct packed {
		logic     load_wr;
		logic     query_cap;
		rsel_t    rsel;
		logic     take_prev;
		logic     take_cur;
		logic     k_init;
		logic     k_inc;
		logic     set_res;
		res_sel_t res_sel;
		logic     eval;
		logic     mul;
		logic     div_step;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic x_le_rd;
		logic x_ge_rd;
		logic x_eq_x0;
		logic x_eq_x1;
		logic x1_eq_x0;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

// File: hdl/piecewise_linear_table_interp.sv
// Top level of the piecewise linear table interpolator.
// Joins pwl_ctrl and pwl_dp; uses pwl_pkg, pwl_dp, pwl_ctrl.
//
// Usage
// - Input channel (in_valid / in_stall): a request is taken when in_valid is
//   high and in_stall low. req_type selects a load (writes point_x/point_y
//   into slot point_index, no result) or a query (one result for query_x).
// - Output channel (out_valid / out_stall): result_y and table_empty, taken
//   when out_valid is high and out_stall low.
// - Config channel (cfg_valid / cfg_ready): cfg_data sets points_in_use.
//   cfg_ready is always high; write only while the block is idle.
// - Timing: a load is written when it is accepted. A query walks the
//   breakpoint RAM one read per cycle, then runs a 64-step serial divider.
//   Only an interpolated result runs the divider; an empty table, a clamp
//   below or above, an exact hit or a zero-width interval skips it. No new
//   request is taken until a query hands its result to the output
//   register; no overlap.
// - Reset: points_in_use clears to 0 (empty table). Breakpoint contents are
//   undefined until loaded.
// - Stall: the output register holds a result while the receiver stalls and
//   the block still accepts the next request; a finished query waits for
//   the output register to free up before the block goes idle again.
module piecewise_linear_table_interp #(
	parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              req_type,
	input  logic [pwl_pkg::IDX_W-1:0]         point_index,
	input  logic signed [pwl_pkg::DATA_W-1:0] point_x,
	input  logic signed [pwl_pkg::DATA_W-1:0] point_y,
	input  logic signed [pwl_pkg::DATA_W-1:0] query_x,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pwl_pkg::DATA_W-1:0] result_y,
	output logic                              table_empty,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pwl_pkg::CFG_W-1:0]         cfg_data
);

	pwl_pkg::cmd_t cmd;
	pwl_pkg::sts_t sts;

	// register write never back-pressures
	assign cfg_ready = 1'b1;

	pwl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.req_type(req_type),
		.sts     (sts),
		.cmd     (cmd),
		.in_stall(in_stall)
	);

	pwl_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.point_index(point_index),
		.point_x    (point_x),
		.point_y    (point_y),
		.query_x    (query_x),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.result_y   (result_y),
		.table_empty(table_empty)
	);

	// output register is loaded only when it is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register loaded while busy");

	// handing off a result returns the block to idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !in_stall)
		else $error("block not idle after result hand-off");

	// a captured query keeps the input stalled
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.query_cap |=> in_stall)
		else $error("input open while a query is in flight");

	// divider only steps after the product was taken
	a_div_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |=> cmd.div_step)
		else $error("divider did not start after multiply");

endmodule

// File: hdl/pwl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/pwl_ctrl.sv
// Controller for the piecewise linear interpolator: sequences table
// search, multiply, serial divide and result hand-off. Uses pwl_pkg.
module pwl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          req_type,
	input  pwl_pkg::sts_t sts,
	output pwl_pkg::cmd_t cmd,
	output logic          in_stall
);

	pwl_pkg::state_t state_q, state_nx;
	logic            accept;

	assign in_stall = (state_q != pwl_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwl_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			pwl_pkg::ST_IDLE: begin
				if (accept && req_type == pwl_pkg::REQ_QUERY) begin
					state_nx = sts.n_zero ? pwl_pkg::ST_DONE : pwl_pkg::ST_FIRST;
				end
			end
			pwl_pkg::ST_FIRST: begin
				state_nx = sts.x_le_rd ? pwl_pkg::ST_DONE : pwl_pkg::ST_LAST;
			end
			pwl_pkg::ST_LAST: begin
				state_nx = sts.x_ge_rd ? pwl_pkg::ST_DONE : pwl_pkg::ST_WALK;
			end
			pwl_pkg::ST_WALK: begin
				if (sts.x_le_rd) begin
					state_nx = pwl_pkg::ST_EVAL;
				end
			end
			pwl_pkg::ST_EVAL: begin
				if (sts.x_eq_x0 || sts.x_eq_x1 || sts.x1_eq_x0) begin
					state_nx = pwl_pkg::ST_DONE;
				end else begin
					state_nx = pwl_pkg::ST_MUL;
				end
			end
			pwl_pkg::ST_MUL: begin
				state_nx = pwl_pkg::ST_DIV;
			end
			pwl_pkg::ST_DIV: begin
				if (sts.div_last) begin
					state_nx = pwl_pkg::ST_FIN;
				end
			end
			pwl_pkg::ST_FIN: begin
				state_nx = pwl_pkg::ST_DONE;
			end
			pwl_pkg::ST_DONE: begin
				if (sts.out_free) begin
					state_nx = pwl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = pwl_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			pwl_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_type == pwl_pkg::REQ_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.query_cap = 1'b1;
						cmd.rsel      = pwl_pkg::RSEL_FIRST;
						if (sts.n_zero) begin
							cmd.set_res = 1'b1;
							cmd.res_sel = pwl_pkg::RES_EMPTY;
						end
					end
				end
			end
			pwl_pkg::ST_FIRST: begin
				cmd.take_prev = 1'b1;
				if (sts.x_le_rd) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = pwl_pkg::RES_RD_Y;
				end else begin
					cmd.rsel = pwl_pkg::RSEL_LAST;
				end
			end
			pwl_pkg::ST_LAST: begin
				if (sts.x_ge_rd) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = pwl_pkg::RES_RD_Y;
				end else begin
					cmd.rsel   = pwl_pkg::RSEL_ONE;
					cmd.k_init = 1'b1;
				end
			end
			pwl_pkg::ST_WALK: begin
				if (sts.x_le_rd) begin
					cmd.take_cur = 1'b1;
				end else begin
					cmd.take_prev = 1'b1;
					cmd.k_inc     = 1'b1;
					cmd.rsel      = pwl_pkg::RSEL_NEXT;
				end
			end
			pwl_pkg::ST_EVAL: begin
				if (sts.x_eq_x0) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = pwl_pkg::RES_PREV_Y;
				end else if (sts.x_eq_x1) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = pwl_pkg::RES_CUR_Y;
				end else if (sts.x1_eq_x0) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = pwl_pkg::RES_PREV_Y;
				end else begin
					cmd.eval = 1'b1;
				end
			end
			pwl_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
			end
			pwl_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			pwl_pkg::ST_FIN: begin
				cmd.set_res = 1'b1;
				cmd.res_sel = pwl_pkg::RES_INTERP;
			end
			pwl_pkg::ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: hdl/pwl_dp.sv
// Datapath for the piecewise linear interpolator: breakpoint RAM, search
// compares, multiplier, serial divider, saturation, output register.
// Uses pwl_pkg and pwl_ram.
module pwl_dp #(
	parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pwl_pkg::cmd_t                       cmd,
	output pwl_pkg::sts_t                       sts,
	input  logic                                cfg_valid,
	input  logic [pwl_pkg::CFG_W-1:0]           cfg_data,
	input  logic [pwl_pkg::IDX_W-1:0]           point_index,
	input  logic signed [pwl_pkg::DATA_W-1:0]   point_x,
	input  logic signed [pwl_pkg::DATA_W-1:0]   point_y,
	input  logic signed [pwl_pkg::DATA_W-1:0]   query_x,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic signed [pwl_pkg::DATA_W-1:0]   result_y,
	output logic                                table_empty
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int NW = $clog2(MAX_POINTS + 1);
	localparam int DW = pwl_pkg::DATA_W;
	localparam int PW = 2 * DW;
	localparam int QW = 41;  // clamped quotient, up to 2^40
	localparam int SW = 43;  // sum width
	localparam logic [PW-1:0] Q_CLAMP = PW'(1) << (QW - 1);
	localparam logic signed [SW-1:0] SAT_HI = SW'(2147483647);
	localparam logic signed [SW-1:0] SAT_LO = -SW'(64'sd2147483648);

	function automatic logic [DW-1:0] mag33(input logic signed [DW:0] v);
		logic signed [DW:0] nv;
		nv = -v;
		mag33 = v[DW] ? nv[DW-1:0] : v[DW-1:0];
	endfunction

	logic [pwl_pkg::CFG_W-1:0] points_q;
	logic [NW-1:0]             n_now, n_q;
	logic [AW-1:0]             last_addr, k_q, raddr, waddr;
	logic                      wr_en;
	logic [PW-1:0]             rdata;
	logic signed [DW-1:0]      rd_x, rd_y;
	logic signed [DW-1:0]      x_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;

	logic signed [DW:0]        dy, dxq, dx;
	logic [DW-1:0]             mdy_q, mdxq_q, mdx_q;
	logic                      neg_q;
	logic [PW-1:0]             prod;
	logic [PW-1:0]             quo_q;
	logic [DW-1:0]             rem_q;
	logic [pwl_pkg::DIV_CW-1:0] cnt_q;
	logic [DW:0]               rem_sh, rem_sub;
	logic                      rem_ge;

	logic [QW-1:0]             qc;
	logic [SW-1:0]             qs;
	logic signed [SW-1:0]      sum;
	logic signed [DW-1:0]      interp_y;

	logic signed [DW-1:0]      res_y_q, out_y_q;
	logic                      res_empty_q, out_empty_q, out_valid_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= '0;
		end else if (cfg_valid) begin
			points_q <= cfg_data;
		end
	end

	// counts above the table depth act as the full table
	always_comb begin
		if (int'(points_q) > MAX_POINTS) begin
			n_now = NW'(MAX_POINTS);
		end else begin
			n_now = NW'(points_q);
		end
	end

	assign last_addr = AW'(n_q - NW'(1));
	assign wr_en     = cmd.load_wr && (int'(point_index) < MAX_POINTS);
	assign waddr     = AW'(point_index);

	always_comb begin
		case (cmd.rsel)
			pwl_pkg::RSEL_FIRST: raddr = '0;
			pwl_pkg::RSEL_LAST:  raddr = last_addr;
			pwl_pkg::RSEL_ONE:   raddr = AW'(1);
			pwl_pkg::RSEL_NEXT:  raddr = k_q + AW'(1);
			default:             raddr = '0;
		endcase
	end

	pwl_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata({point_x, point_y}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_x = rdata[PW-1:DW];
	assign rd_y = rdata[DW-1:0];

	// search registers
	always_ff @(posedge clk) begin
		if (cmd.query_cap) begin
			x_q <= query_x;
			n_q <= n_now;
		end
		if (cmd.take_prev) begin
			prev_x_q <= rd_x;
			prev_y_q <= rd_y;
		end
		if (cmd.take_cur) begin
			cur_x_q <= rd_x;
			cur_y_q <= rd_y;
		end
		if (cmd.k_init) begin
			k_q <= AW'(1);
		end else if (cmd.k_inc) begin
			k_q <= k_q + AW'(1);
		end
	end

	// interval setup: magnitudes and sign of the quotient
	assign dy  = {cur_y_q[DW-1], cur_y_q} - {prev_y_q[DW-1], prev_y_q};
	assign dxq = {x_q[DW-1], x_q} - {prev_x_q[DW-1], prev_x_q};
	assign dx  = {cur_x_q[DW-1], cur_x_q} - {prev_x_q[DW-1], prev_x_q};

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			mdy_q  <= mag33(dy);
			mdxq_q <= mag33(dxq);
			mdx_q  <= mag33(dx);
			neg_q  <= dy[DW] ^ dxq[DW] ^ dx[DW];
		end
	end

	// multiply, then restoring division one bit per cycle
	assign prod    = mdy_q * mdxq_q;
	assign rem_sh  = {rem_q, quo_q[PW-1]};
	assign rem_ge  = rem_sh >= {1'b0, mdx_q};
	assign rem_sub = rem_sh - {1'b0, mdx_q};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			quo_q <= prod;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[PW-2:0], rem_ge};
			rem_q <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			cnt_q <= cnt_q + pwl_pkg::DIV_CW'(1);
		end
	end

	// clamp, apply sign, add left y, saturate
	always_comb begin
		qc = (quo_q > Q_CLAMP) ? Q_CLAMP[QW-1:0] : quo_q[QW-1:0];
		qs = {2'b00, qc};
		if (neg_q) begin
			qs = -qs;
		end
		sum = SW'(prev_y_q) + $signed(qs);
		if (sum > SAT_HI) begin
			interp_y = SAT_HI[DW-1:0];
		end else if (sum < SAT_LO) begin
			interp_y = SAT_LO[DW-1:0];
		end else begin
			interp_y = sum[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_empty_q <= (cmd.res_sel == pwl_pkg::RES_EMPTY);
			case (cmd.res_sel)
				pwl_pkg::RES_EMPTY:  res_y_q <= '0;
				pwl_pkg::RES_RD_Y:   res_y_q <= rd_y;
				pwl_pkg::RES_PREV_Y: res_y_q <= prev_y_q;
				pwl_pkg::RES_CUR_Y:  res_y_q <= cur_y_q;
				pwl_pkg::RES_INTERP: res_y_q <= interp_y;
				default:             res_y_q <= '0;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_y_q     <= res_y_q;
			out_empty_q <= res_empty_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_y    = out_y_q;
	assign table_empty = out_empty_q;

	assign sts.n_zero   = (points_q == '0);
	assign sts.x_le_rd  = (x_q <= rd_x);
	assign sts.x_ge_rd  = (x_q >= rd_x);
	assign sts.x_eq_x0  = (x_q == prev_x_q);
	assign sts.x_eq_x1  = (x_q == cur_x_q);
	assign sts.x1_eq_x0 = (cur_x_q == prev_x_q);
	assign sts.div_last = (cnt_q == pwl_pkg::DIV_CW'(pwl_pkg::DIV_STEPS - 1));
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule
